@@ sv/assert_macros.svh @@
// assertion macros used by the speed control core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ sv/dwpid_pkg.sv @@
// types and constants of the dual wheel pid speed control core
`timescale 1ns / 1ps
package dwpid_pkg;

   localparam int GAIN_W   = 16;
   localparam int TICK_W   = 10;
   localparam int SPD_W    = 16;
   localparam int ERR_W    = 17;
   localparam int INTEG_W  = 32;
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = 17;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_TRACK = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE  = 3'd4;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd6400;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd1024;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd26;
   localparam logic [GAIN_W-1:0] HALF_TRACK_RST = 16'd10158;
   localparam logic [TICK_W-1:0] TICK_RATE_RST  = 10'd100;

   typedef struct packed {
      logic signed [SPD_W-1:0] linear_target;
      logic signed [SPD_W-1:0] angular_target;
      logic signed [SPD_W-1:0] left_measured;
      logic signed [SPD_W-1:0] right_measured;
      logic                    stop_toggle;
      logic                    led_request;
   } req_payload_type;

   typedef struct packed {
      logic signed [SPD_W-1:0] left_drive;
      logic signed [SPD_W-1:0] right_drive;
      logic                    led_on;
      logic                    stopped;
   } rsp_payload_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] deriv_gain;
      logic [TICK_W-1:0] tick_rate;
   } gain_cfg_type;

   typedef struct packed {
      logic                    start;
      logic signed [SPD_W-1:0] goal;
      logic signed [SPD_W-1:0] meas;
   } lane_cmd_type;

   typedef struct packed {
      logic                    done;
      logic signed [SPD_W-1:0] drive;
   } lane_rsp_type;

   typedef struct packed {
      logic signed [SPD_W-1:0] left_drive;
      logic signed [SPD_W-1:0] right_drive;
      logic                    led_on;
      logic                    stopped;
   } merge_in_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_SPLIT,
      CTL_TARGET,
      CTL_RUN,
      CTL_PUSH
   } ctl_state_type;

   typedef enum logic [2:0] {
      LN_IDLE,
      LN_ERR,
      LN_MP,
      LN_MI,
      LN_MDT,
      LN_MD,
      LN_MSUB,
      LN_RND
   } lane_state_type;

endpackage

@@ sv/dual_wheel_pid_speed_control_core.sv @@
// an accepted request runs through split, target, the 7-step wheel lane sequence and the push;
// a new request is taken only once the core is back in idle after the push
// both wheels run in parallel lanes; the response register frees the front for the next request
// a stalled response holds the next request in the push step until the output frees
// reset restores the gain registers to their defaults and clears the stop flag,
// the wheel integrators and the last error and last speed of both wheels
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dual_wheel_pid_speed_control_core
   import dwpid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata
);

   ctl_state_type state_ff, state_in;

   logic [GAIN_W-1:0] prop_gain_ff, prop_gain_in;
   logic [GAIN_W-1:0] integ_gain_ff, integ_gain_in;
   logic [GAIN_W-1:0] deriv_gain_ff, deriv_gain_in;
   logic [GAIN_W-1:0] half_track_ff, half_track_in;
   logic [TICK_W-1:0] tick_rate_ff, tick_rate_in;

   logic            stop_ff, stop_in;
   req_payload_type item_ff, item_in;
   logic signed [MUL_A_W:0] wprod_ff, wprod_in;
   logic signed [SPD_W-1:0] left_drive_ff, left_drive_in;
   logic signed [SPD_W-1:0] right_drive_ff, right_drive_in;

   logic                    req_accept;
   logic                    lane_start;
   logic                    merge_load;
   logic                    merge_ready;
   logic signed [MUL_A_W-1:0] wmul;
   logic signed [SPD_W+1:0]   wd;
   logic signed [SPD_W+2:0]   gl_wide;
   logic signed [SPD_W+2:0]   gr_wide;
   logic signed [SPD_W-1:0]   gl_sat;
   logic signed [SPD_W-1:0]   gr_sat;

   gain_cfg_type gains;
   lane_cmd_type left_cmd, right_cmd;
   lane_rsp_type left_rsp, right_rsp;
   merge_in_type merge_data;

   // register file
   always_comb begin
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      half_track_in = half_track_ff;
      tick_rate_in  = tick_rate_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PROP_GAIN:  prop_gain_in  = csr_wdata;
            CSR_INTEG_GAIN: integ_gain_in = csr_wdata;
            CSR_DERIV_GAIN: deriv_gain_in = csr_wdata;
            CSR_HALF_TRACK: half_track_in = csr_wdata;
            CSR_TICK_RATE:  tick_rate_in  = csr_wdata[TICK_W-1:0];
            default:        prop_gain_in  = prop_gain_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               state_in = CTL_SPLIT;
            end
         end
         CTL_SPLIT:  state_in = CTL_TARGET;
         CTL_TARGET: state_in = CTL_RUN;
         CTL_RUN: begin
            if (left_rsp.done) begin
               state_in = CTL_PUSH;
            end
         end
         CTL_PUSH: begin
            if (merge_ready) begin
               state_in = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall  = 1'b1;
      lane_start = 1'b0;
      merge_load = 1'b0;
      case (state_ff)
         CTL_IDLE:   req_stall  = 1'b0;
         CTL_TARGET: lane_start = 1'b1;
         CTL_PUSH:   merge_load = merge_ready;
         default:    req_stall  = 1'b1;
      endcase
   end

   assign req_accept = req_valid && !req_stall;

   // wheel offset: w * half_track, rounded half up to q3.12
   assign wmul = item_ff.angular_target * $signed({1'b0, half_track_ff});

   always_comb begin
      stop_in  = stop_ff;
      item_in  = item_ff;
      wprod_in = wprod_ff;
      if (req_accept) begin
         item_in = req_payload;
         stop_in = stop_ff ^ req_payload.stop_toggle;
      end
      if (state_ff == CTL_SPLIT) begin
         wprod_in = {wmul[MUL_A_W-1], wmul} + (MUL_A_W+1)'(32768);
      end
   end

   assign wd      = wprod_ff[MUL_A_W:16];
   assign gl_wide = {{3{item_ff.linear_target[SPD_W-1]}}, item_ff.linear_target}
                  - {wd[SPD_W+1], wd};
   assign gr_wide = {{3{item_ff.linear_target[SPD_W-1]}}, item_ff.linear_target}
                  + {wd[SPD_W+1], wd};

   always_comb begin
      if ((&gl_wide[SPD_W+2:SPD_W-1]) || !(|gl_wide[SPD_W+2:SPD_W-1])) begin
         gl_sat = gl_wide[SPD_W-1:0];
      end else if (gl_wide[SPD_W+2]) begin
         gl_sat = {1'b1, {(SPD_W-1){1'b0}}};
      end else begin
         gl_sat = {1'b0, {(SPD_W-1){1'b1}}};
      end
      if ((&gr_wide[SPD_W+2:SPD_W-1]) || !(|gr_wide[SPD_W+2:SPD_W-1])) begin
         gr_sat = gr_wide[SPD_W-1:0];
      end else if (gr_wide[SPD_W+2]) begin
         gr_sat = {1'b1, {(SPD_W-1){1'b0}}};
      end else begin
         gr_sat = {1'b0, {(SPD_W-1){1'b1}}};
      end
   end

   // lane drives are captured when the lanes finish and hold until they next finish
   always_comb begin
      left_drive_in  = left_drive_ff;
      right_drive_in = right_drive_ff;
      if (left_rsp.done) begin
         left_drive_in  = left_rsp.drive;
         right_drive_in = right_rsp.drive;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CTL_IDLE;
         stop_ff       <= 1'b0;
         prop_gain_ff  <= PROP_GAIN_RST;
         integ_gain_ff <= INTEG_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
         half_track_ff <= HALF_TRACK_RST;
         tick_rate_ff  <= TICK_RATE_RST;
      end else begin
         state_ff      <= state_in;
         stop_ff       <= stop_in;
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         deriv_gain_ff <= deriv_gain_in;
         half_track_ff <= half_track_in;
         tick_rate_ff  <= tick_rate_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      wprod_ff       <= wprod_in;
      left_drive_ff  <= left_drive_in;
      right_drive_ff <= right_drive_in;
   end

   assign gains.prop_gain  = prop_gain_ff;
   assign gains.integ_gain = integ_gain_ff;
   assign gains.deriv_gain = deriv_gain_ff;
   assign gains.tick_rate  = tick_rate_ff;

   assign left_cmd.start  = lane_start;
   assign left_cmd.goal   = gl_sat;
   assign left_cmd.meas   = item_ff.left_measured;
   assign right_cmd.start = lane_start;
   assign right_cmd.goal  = gr_sat;
   assign right_cmd.meas  = item_ff.right_measured;

   dwpid_lane u_lane_left (
      .clock (clock),
      .reset (reset),
      .gains (gains),
      .cmd   (left_cmd),
      .rsp   (left_rsp)
   );

   dwpid_lane u_lane_right (
      .clock (clock),
      .reset (reset),
      .gains (gains),
      .cmd   (right_cmd),
      .rsp   (right_rsp)
   );

   assign merge_data.left_drive  = left_drive_ff;
   assign merge_data.right_drive = right_drive_ff;
   assign merge_data.led_on      = item_ff.led_request;
   assign merge_data.stopped     = stop_ff;

   dwpid_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (merge_load),
      .data        (merge_data),
      .ready       (merge_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `ASSERT_IMPLY(a_lane_lockstep, clock, reset, left_rsp.done || right_rsp.done, left_rsp.done && right_rsp.done, "wheel lanes out of step")
   `ASSERT_IMPLY(a_done_in_run, clock, reset, left_rsp.done, state_ff == CTL_RUN, "lane finished outside run state")
   `ASSERT_IMPLY(a_load_has_room, clock, reset, merge_load, merge_ready, "response loaded while output full")
   `ASSERT_NEXT(a_stop_toggles, clock, reset, req_accept && req_payload.stop_toggle, stop_ff != $past(stop_ff), "stop flag did not toggle")

endmodule

@@ sv/dwpid_lane.sv @@
// one wheel pid lane with a shared multiplier stepped by a small sequencer
`timescale 1ns / 1ps
module dwpid_lane
   import dwpid_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  gain_cfg_type gains,
   input  lane_cmd_type cmd,
   output lane_rsp_type rsp
);

   lane_state_type state_ff, state_in;

   logic signed [SPD_W-1:0]   goal_ff, goal_in;
   logic signed [SPD_W-1:0]   meas_ff, meas_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   last_err_ff, last_err_in;
   logic signed [SPD_W-1:0]   last_spd_ff, last_spd_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [INTEG_W-1:0] acc_ff, acc_in;
   logic signed [ERR_W-1:0]   dspd_ff, dspd_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [SPD_W-1:0]   drive_ff, drive_in;

   logic signed [ERR_W-1:0]     err_calc;
   logic signed [ERR_W-1:0]     dspd_calc;
   logic signed [INTEG_W+1:0]   acc_wide;
   logic signed [INTEG_W-1:0]   acc_sat;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]    mul_p;
   logic signed [SUM_W-1:0]     rnd;
   logic signed [SUM_W-14:0]    shifted;
   logic signed [SPD_W-1:0]     drive_sat;
   logic                        done;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LN_IDLE: begin
            if (cmd.start) begin
               state_in = LN_ERR;
            end
         end
         LN_ERR:  state_in = LN_MP;
         LN_MP:   state_in = LN_MI;
         LN_MI:   state_in = LN_MDT;
         LN_MDT:  state_in = LN_MD;
         LN_MD:   state_in = LN_MSUB;
         LN_MSUB: state_in = LN_RND;
         LN_RND:  state_in = LN_IDLE;
         default: state_in = LN_IDLE;
      endcase
   end

   // multiplier operand select and done
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      done  = 1'b0;
      case (state_ff)
         LN_MP: begin
            mul_a = {{(MUL_A_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
            mul_b = {1'b0, gains.prop_gain};
         end
         LN_MI: begin
            mul_a = {{(MUL_A_W-INTEG_W){acc_ff[INTEG_W-1]}}, acc_ff};
            mul_b = {1'b0, gains.integ_gain};
         end
         LN_MDT: begin
            mul_a = {{(MUL_A_W-ERR_W){dspd_ff[ERR_W-1]}}, dspd_ff};
            mul_b = {{(MUL_B_W-TICK_W){1'b0}}, gains.tick_rate};
         end
         LN_MD: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = {1'b0, gains.deriv_gain};
         end
         LN_RND: begin
            done = 1'b1;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign err_calc  = {goal_ff[SPD_W-1], goal_ff} - {meas_ff[SPD_W-1], meas_ff};
   assign dspd_calc = {meas_ff[SPD_W-1], meas_ff} - {last_spd_ff[SPD_W-1], last_spd_ff};
   assign acc_wide  = {{2{integ_ff[INTEG_W-1]}}, integ_ff}
                    + {{(INTEG_W+2-ERR_W){err_calc[ERR_W-1]}}, err_calc}
                    + {{(INTEG_W+2-ERR_W){last_err_ff[ERR_W-1]}}, last_err_ff};

   always_comb begin
      if ((acc_wide[INTEG_W+1:INTEG_W-1] == 3'b000) ||
          (acc_wide[INTEG_W+1:INTEG_W-1] == 3'b111)) begin
         acc_sat = acc_wide[INTEG_W-1:0];
      end else if (acc_wide[INTEG_W+1]) begin
         acc_sat = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(INTEG_W-1){1'b1}}};
      end
   end

   // round half up to q8.8, then saturate
   assign rnd     = sum_ff + SUM_W'(4096);
   assign shifted = rnd[SUM_W-1:13];

   always_comb begin
      if ((&shifted[SUM_W-14:SPD_W-1]) || !(|shifted[SUM_W-14:SPD_W-1])) begin
         drive_sat = shifted[SPD_W-1:0];
      end else if (shifted[SUM_W-14]) begin
         drive_sat = {1'b1, {(SPD_W-1){1'b0}}};
      end else begin
         drive_sat = {1'b0, {(SPD_W-1){1'b1}}};
      end
   end

   always_comb begin
      goal_in     = goal_ff;
      meas_in     = meas_ff;
      integ_in    = integ_ff;
      last_err_in = last_err_ff;
      last_spd_in = last_spd_ff;
      err_in      = err_ff;
      acc_in      = acc_ff;
      dspd_in     = dspd_ff;
      prod_in     = prod_ff;
      sum_in      = sum_ff;
      drive_in    = drive_ff;
      case (state_ff)
         LN_IDLE: begin
            if (cmd.start) begin
               goal_in = cmd.goal;
               meas_in = cmd.meas;
            end
         end
         LN_ERR: begin
            err_in      = err_calc;
            acc_in      = acc_sat;
            dspd_in     = dspd_calc;
            integ_in    = acc_sat;
            last_err_in = err_calc;
            last_spd_in = meas_ff;
         end
         LN_MP: begin
            prod_in = mul_p;
         end
         LN_MI: begin
            prod_in = mul_p;
            sum_in  = {prod_ff[PROD_W-1], prod_ff, 1'b0};
         end
         LN_MDT: begin
            prod_in = mul_p;
            sum_in  = sum_ff + {{2{prod_ff[PROD_W-1]}}, prod_ff};
         end
         LN_MD: begin
            prod_in = mul_p;
         end
         LN_MSUB: begin
            sum_in = sum_ff - {prod_ff[PROD_W-1], prod_ff, 1'b0};
         end
         LN_RND: begin
            drive_in = drive_sat;
         end
         default: begin
            drive_in = drive_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= LN_IDLE;
         integ_ff    <= '0;
         last_err_ff <= '0;
         last_spd_ff <= '0;
      end else begin
         state_ff    <= state_in;
         integ_ff    <= integ_in;
         last_err_ff <= last_err_in;
         last_spd_ff <= last_spd_in;
      end
   end

   always_ff @(posedge clock) begin
      goal_ff  <= goal_in;
      meas_ff  <= meas_in;
      err_ff   <= err_in;
      acc_ff   <= acc_in;
      dspd_ff  <= dspd_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      drive_ff <= drive_in;
   end

   assign rsp.done  = done;
   assign rsp.drive = drive_sat;

endmodule

@@ sv/dwpid_merge.sv @@
// merge stage: joins the two lane drives, applies the stop flag, holds the response
`timescale 1ns / 1ps
module dwpid_merge
   import dwpid_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  merge_in_type    data,
   output logic            ready,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type payload_ff, payload_in;

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in   = valid_ff && rsp_stall;
      payload_in = payload_ff;
      if (load) begin
         valid_in               = 1'b1;
         payload_in.left_drive  = data.stopped ? '0 : data.left_drive;
         payload_in.right_drive = data.stopped ? '0 : data.right_drive;
         payload_in.led_on      = data.led_on;
         payload_in.stopped     = data.stopped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

@@ verif/tb_top.sv @@
// testbench for the dual wheel pid speed control core with a self-checking scoreboard
`timescale 1ns / 1ps
module tb_top;
   import dwpid_pkg::*;

   localparam longint ACC_MAX = 64'sd2147483647;
   localparam longint ACC_MIN = -64'sd2147483648;
   localparam longint DRIVE_MAX = 32767;
   localparam longint DRIVE_MIN = -32768;
   localparam int SAT_TICKS = 60;

   class drive_scoreboard;
      longint prop_gain, integ_gain, deriv_gain, half_track, tick_rate;
      bit stop_flag;
      longint integ[2];
      longint last_err[2];
      longint last_spd[2];
      rsp_payload_type expected_drives[$];
      int errors;

      function new();
         prop_gain = PROP_GAIN_RST;
         integ_gain = INTEG_GAIN_RST;
         deriv_gain = DERIV_GAIN_RST;
         half_track = HALF_TRACK_RST;
         tick_rate = TICK_RATE_RST;
         stop_flag = 1'b0;
         for (int k = 0; k < 2; k++) begin
            integ[k] = 0;
            last_err[k] = 0;
            last_spd[k] = 0;
         end
         errors = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
         case (idx)
            CSR_PROP_GAIN:  prop_gain = data;
            CSR_INTEG_GAIN: integ_gain = data;
            CSR_DERIV_GAIN: deriv_gain = data;
            CSR_HALF_TRACK: half_track = data;
            CSR_TICK_RATE:  tick_rate = data[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp(longint x, longint lo, longint hi);
         if (x < lo) return lo;
         if (x > hi) return hi;
         return x;
      endfunction

      // one wheel loop: trapezoid integral, derivative on measurement
      function longint wheel_drive(int k, longint goal, longint meas);
         longint err, acc, total;
         err = goal - meas;
         acc = clamp(integ[k] + err + last_err[k], ACC_MIN, ACC_MAX);
         total = 2 * prop_gain * err + integ_gain * acc
               - 2 * deriv_gain * (meas - last_spd[k]) * tick_rate;
         integ[k] = acc;
         last_err[k] = err;
         last_spd[k] = meas;
         return clamp((total + 4096) >>> 13, DRIVE_MIN, DRIVE_MAX);
      endfunction

      function void note_request(req_payload_type r);
         longint v, w, offset, dl, dr;
         rsp_payload_type e;
         v = r.linear_target;
         w = r.angular_target;
         offset = (w * half_track + 32768) >>> 16;
         if (r.stop_toggle) stop_flag = !stop_flag;
         dl = wheel_drive(0, clamp(v - offset, DRIVE_MIN, DRIVE_MAX), r.left_measured);
         dr = wheel_drive(1, clamp(v + offset, DRIVE_MIN, DRIVE_MAX), r.right_measured);
         if (stop_flag) begin
            dl = 0;
            dr = 0;
         end
         e.left_drive = dl[SPD_W-1:0];
         e.right_drive = dr[SPD_W-1:0];
         e.led_on = r.led_request;
         e.stopped = stop_flag;
         expected_drives.push_back(e);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("%0t ns: mismatch: %s", $time, msg);
      endtask

      task check_response(rsp_payload_type got);
         rsp_payload_type e;
         if (expected_drives.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         e = expected_drives.pop_front();
         if (got.left_drive !== e.left_drive)
            report_mismatch($sformatf("left_drive %0d, want %0d", got.left_drive, e.left_drive));
         if (got.right_drive !== e.right_drive)
            report_mismatch($sformatf("right_drive %0d, want %0d",
                                      got.right_drive, e.right_drive));
         if (got.led_on !== e.led_on)
            report_mismatch($sformatf("led_on %b, want %b", got.led_on, e.led_on));
         if (got.stopped !== e.stopped)
            report_mismatch($sformatf("stopped %b, want %b", got.stopped, e.stopped));
      endtask

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_payload_type rsp_payload;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0] csr_wdata;
   bit calm;
   int stall_hold;
   drive_scoreboard sb;

   dual_wheel_pid_speed_control_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
      end
   end

   always @(negedge clock) begin
      if (calm || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < 35);
         if ($urandom_range(199) == 0) stall_hold <= $urandom_range(30, 10);
      end
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [15:0] extreme_value();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'h0001;
      endcase
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int unsigned pick;
      int v, w, a, b;
      pick = $urandom_range(99);
      v = int'($urandom_range(8192)) - 4096;
      w = int'($urandom_range(8192)) - 4096;
      a = v + int'($urandom_range(1024)) - 512;
      b = v + int'($urandom_range(1024)) - 512;
      if (pick < 40) begin
         // measured speeds tracking the targets
         r.linear_target = v[15:0];
         r.angular_target = w[15:0];
         r.left_measured = a[15:0];
         r.right_measured = b[15:0];
      end else if (pick < 75) begin
         r.linear_target = 16'($urandom);
         r.angular_target = 16'($urandom);
         r.left_measured = 16'($urandom);
         r.right_measured = 16'($urandom);
      end else begin
         r.linear_target = extreme_value();
         r.angular_target = extreme_value();
         r.left_measured = extreme_value();
         r.right_measured = extreme_value();
      end
      r.stop_toggle = ($urandom_range(9) == 0);
      r.led_request = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic send_request(input req_payload_type r);
      @(negedge clock);
      req_valid = 1'b1;
      req_payload = r;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic pause_sender(input int cycles);
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      @(negedge clock);
      req_valid = 1'b0;
      req_payload = bits[$bits(req_payload_type)-1:0];
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_paced(input req_payload_type r);
      if (!calm && $urandom_range(99) < 35) pause_sender($urandom_range(14, 1));
      send_request(r);
   endtask

   task automatic send_tick(input logic [15:0] v, w, ml, mr, input logic tog, led);
      req_payload_type r;
      r.linear_target = v;
      r.angular_target = w;
      r.left_measured = ml;
      r.right_measured = mr;
      r.stop_toggle = tog;
      r.led_request = led;
      send_paced(r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      sb.write_register(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_gains(input logic [15:0] kp, ki, kd, ht, rate);
      wait_idle();
      write_csr(CSR_PROP_GAIN, kp);
      write_csr(CSR_INTEG_GAIN, ki);
      write_csr(CSR_DERIV_GAIN, kd);
      write_csr(CSR_HALF_TRACK, ht);
      write_csr(CSR_TICK_RATE, rate);
      // unmapped index, must be ignored
      write_csr(CSR_IDX_W'(CSR_TICK_RATE + 1 + $urandom_range(2)), 16'($urandom));
   endtask

   initial begin
      req_payload_type sat;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_PROP_GAIN;
      csr_wdata = '0;
      calm = 1'b0;
      stall_hold = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_tick(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
      send_tick(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_tick(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 1'b1);
      send_tick(16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_tick(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0, 1'b1);
      send_tick(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, 1'b0);
      send_tick(16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0, 1'b1);
      // stop on, state keeps moving while stopped, then stop off
      send_tick(16'h1000, 16'h0800, 16'h0F00, 16'h1100, 1'b1, 1'b1);
      send_tick(16'h1000, 16'h0800, 16'h0F80, 16'h1080, 1'b0, 1'b0);
      send_tick(16'h1000, 16'h0800, 16'h0FC0, 16'h1040, 1'b1, 1'b1);
      send_tick(16'hF000, 16'hF800, 16'hF100, 16'hEF00, 1'b1, 1'b0);
      send_tick(16'hF000, 16'hF800, 16'hF100, 16'hEF00, 1'b1, 1'b1);
      // tick rate zero removes the derivative term
      load_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, HALF_TRACK_RST, 16'h0000);
      send_tick(16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 1'b0, 1'b0);
      send_tick(16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0, 1'b1);
      load_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, HALF_TRACK_RST, 16'h03FF);
      send_tick(16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 1'b0, 1'b1);
      send_tick(16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0, 1'b0);
      load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, 1'b1);
      send_tick(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: load_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, HALF_TRACK_RST,
                          GAIN_W'(TICK_RATE_RST));
            1: load_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
            2: load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
            default: load_gains(16'($urandom_range(12800)), 16'($urandom_range(4096)),
                                16'($urandom_range(512)), 16'($urandom),
                                16'($urandom_range(1023)));
         endcase
         calm = (ph == 4);
         for (int n = 0; n < 200; n++) begin
            if (ph == 5 && n == 100) wait_idle();
            send_paced(random_request());
         end
      end

      // push both integrators hard, left up and right down
      load_gains(16'h0000, 16'h0001, 16'h0000, 16'hFFFF, GAIN_W'(TICK_RATE_RST));
      calm = 1'b1;
      sat.linear_target = 16'h0000;
      sat.angular_target = 16'h8000;
      sat.left_measured = 16'h8000;
      sat.right_measured = 16'h7FFF;
      sat.led_request = 1'b1;
      sat.stop_toggle = sb.stop_flag;
      send_request(sat);
      sat.stop_toggle = 1'b0;
      repeat (SAT_TICKS) send_request(sat);
      calm = 1'b0;
      load_gains(16'($urandom_range(12800)), 16'($urandom_range(3)), 16'($urandom_range(512)),
                 HALF_TRACK_RST, GAIN_W'(TICK_RATE_RST));
      repeat (40) send_paced(random_request());

      wait_idle();
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
